FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the windowed throughput meter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define WTM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define WTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hdl/wtm_pkg.sv
// ----------------------------------------------------------------------------
// wtm_pkg
// field widths, constants and control types of the windowed throughput meter
// ----------------------------------------------------------------------------
package wtm_pkg;

  // field widths
  localparam int unsigned BYTES_W   = 24;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned TOTAL_W   = 48;
  localparam int unsigned SPEED_W   = 36;
  localparam int unsigned TIME_W    = 31;
  localparam int unsigned REM_SPLIT = 24;

  // default ring depth
  localparam int unsigned DEFAULT_WINDOW_DEPTH = 16;

  // (bytes/1024) / (ms/1000) * 256 reduces to bytes*250/ms
  localparam int unsigned SPEED_SCALE = 250;

  // configuration port
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE = 1'b0;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_TDIV,
    ST_WAIT
  } wtm_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic spd_start;
    logic tim_start;
    logic load_out;
  } wtm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic spd_busy;
    logic tim_busy;
  } wtm_status_t;

endpackage

FILE: hdl/wtm_divider.sv
// ----------------------------------------------------------------------------
// wtm_divider
// restoring divider, one quotient bit per cycle, saturating quotient
// ----------------------------------------------------------------------------
module wtm_divider #(
  parameter int unsigned DVD_W = 36,
  parameter int unsigned DVS_W = 20,
  parameter int unsigned QUO_W = 36
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [QUO_W-1:0] quotient_o
);

  localparam int unsigned EXT_W = (DVD_W > QUO_W) ? DVD_W : QUO_W + 1;
  localparam int unsigned TOP_W = EXT_W - QUO_W;
  localparam int unsigned CMP_W = (TOP_W > DVS_W) ? TOP_W : DVS_W;
  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic [EXT_W-1:0] ext;
  logic [TOP_W-1:0] top;
  logic             sat;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q;
  logic             sat_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             bit_in;
  logic [DVS_W+1:0] diff;
  logic             borrow;

  // bits above the quotient range: at or above the divisor means overflow
  assign ext = EXT_W'(dividend_i);
  assign top = ext[EXT_W-1:QUO_W];
  assign sat = CMP_W'(top) >= CMP_W'(divisor_i);

  // trial subtract of the shifted partial remainder
  assign bit_in = quo_q[QUO_W-1];
  assign diff   = {1'b0, rem_q, bit_in} - {2'b00, dvs_q};
  assign borrow = diff[DVS_W+1];

  // next iteration values
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = DVS_W'(top);
      quo_d = ext[QUO_W-1:0];
      cnt_d = CNT_W'(QUO_W);
    end else if (busy_o) begin
      rem_d = borrow ? {rem_q[DVS_W-2:0], bit_in} : diff[DVS_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], ~borrow};
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
      sat_q <= sat;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = sat_q ? {QUO_W{1'b1}} : quo_q;

endmodule

FILE: hdl/wtm_datapath.sv
// ----------------------------------------------------------------------------
// wtm_datapath
// sample ring, window sums, transfer total, multiplier, dividers, result regs
// ----------------------------------------------------------------------------
module wtm_datapath #(
  parameter int unsigned WINDOW_DEPTH = wtm_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wtm_pkg::wtm_cmd_t            cmd_i,
  output wtm_pkg::wtm_status_t         status_o,
  input  logic [wtm_pkg::BYTES_W-1:0]  bytes_sent_i,
  input  logic [wtm_pkg::MS_W-1:0]     elapsed_ms_i,
  input  logic [wtm_pkg::TOTAL_W-1:0]  file_size_i,
  output logic [wtm_pkg::SPEED_W-1:0]  speed_q8_o,
  output logic [wtm_pkg::TIME_W-1:0]   time_left_ms_o,
  output logic                         no_rate_o,
  output logic [wtm_pkg::TOTAL_W-1:0]  total_sent_o
);

  import wtm_pkg::*;

  localparam int unsigned IDX_W      = $clog2(WINDOW_DEPTH);
  localparam int unsigned WB_W       = BYTES_W + IDX_W;
  localparam int unsigned WMS_W      = MS_W + IDX_W;
  localparam int unsigned ENTRY_W    = BYTES_W + MS_W;
  localparam int unsigned SPD_DVD_W  = WB_W + 8;
  localparam int unsigned PP_W       = REM_SPLIT + WMS_W;
  localparam int unsigned PROD_W     = TOTAL_W + WMS_W;

  // ring storage
  logic [ENTRY_W-1:0]      ring_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] vld_q;
  logic [ENTRY_W-1:0]      rd_q;
  logic                    rd_vld_q;
  logic [IDX_W-1:0]        head_q, head_nxt;

  // sample and window state
  logic [BYTES_W-1:0] b_q;
  logic [MS_W-1:0]    t_q;
  logic [BYTES_W-1:0] old_b;
  logic [MS_W-1:0]    old_t;
  logic [WB_W-1:0]    wb_q;
  logic [WMS_W-1:0]   wms_q;
  logic [TOTAL_W-1:0] total_q;
  logic [TOTAL_W:0]   total_sum;

  // estimate path
  logic [TOTAL_W-1:0]   rem;
  logic [REM_SPLIT-1:0] mul_a;
  logic [PP_W-1:0]      mul_p;
  logic [PP_W-1:0]      pp_lo_q, pp_hi_q;
  logic [PROD_W-1:0]    prod_q;
  logic [SPD_DVD_W-1:0] spd_dvd_q;
  logic                 no_rate_q;
  logic [SPEED_W-1:0]   spd_quo;
  logic [TIME_W-1:0]    tim_quo;

  // head advance with wrap
  assign head_nxt = (head_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);

  // ring write on update, registered read of the slot being replaced
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      ring_mem[head_q] <= {b_q, t_q};
    end
    if (cmd_i.accept) begin
      rd_q <= ring_mem[head_nxt];
    end
  end

  // slot valid bits and head pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      head_q   <= '0;
    end else begin
      if (cmd_i.accept) begin
        rd_vld_q <= vld_q[head_nxt];
        head_q   <= head_nxt;
      end
      if (cmd_i.update) begin
        vld_q[head_q] <= 1'b1;
      end
    end
  end

  // capture the incoming item
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      b_q <= bytes_sent_i;
      t_q <= elapsed_ms_i;
    end
  end

  // a never written slot reads as zero
  assign old_b = rd_vld_q ? rd_q[ENTRY_W-1:MS_W] : '0;
  assign old_t = rd_vld_q ? rd_q[MS_W-1:0] : '0;

  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(b_q);

  // running window sums and saturating total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q    <= '0;
      wms_q   <= '0;
      total_q <= '0;
    end else if (cmd_i.update) begin
      wb_q    <= wb_q - WB_W'(old_b) + WB_W'(b_q);
      wms_q   <= wms_q - WMS_W'(old_t) + WMS_W'(t_q);
      total_q <= total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
    end
  end

  // bytes left, clamped at zero
  assign rem = (total_q > file_size_i) ? '0 : file_size_i - total_q;

  // one 24-bit by window-ms multiplier, low half then high half
  assign mul_a = cmd_i.mul_hi ? rem[TOTAL_W-1:REM_SPLIT] : rem[REM_SPLIT-1:0];
  assign mul_p = PP_W'(mul_a) * PP_W'(wms_q);

  // partial products, speed dividend and empty-window flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      pp_lo_q   <= mul_p;
      spd_dvd_q <= SPD_DVD_W'(wb_q) * SPD_DVD_W'(SPEED_SCALE);
      no_rate_q <= (wb_q == '0) || (wms_q == '0);
    end
    if (cmd_i.mul_hi) begin
      pp_hi_q <= mul_p;
    end
    if (cmd_i.sum) begin
      prod_q <= {pp_hi_q, {REM_SPLIT{1'b0}}} + PROD_W'(pp_lo_q);
    end
  end

  // speed: window bytes * 250 / window ms
  wtm_divider #(
    .DVD_W (SPD_DVD_W),
    .DVS_W (WMS_W),
    .QUO_W (SPEED_W)
  ) u_spd_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.spd_start),
    .dividend_i (spd_dvd_q),
    .divisor_i  (wms_q),
    .busy_o     (status_o.spd_busy),
    .quotient_o (spd_quo)
  );

  // time left: remaining * window ms / window bytes
  wtm_divider #(
    .DVD_W (PROD_W),
    .DVS_W (WB_W),
    .QUO_W (TIME_W)
  ) u_tim_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.tim_start),
    .dividend_i (prod_q),
    .divisor_i  (wb_q),
    .busy_o     (status_o.tim_busy),
    .quotient_o (tim_quo)
  );

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      speed_q8_o     <= no_rate_q ? '0 : spd_quo;
      time_left_ms_o <= no_rate_q ? '0 : tim_quo;
      no_rate_o      <= no_rate_q;
      total_sent_o   <= total_q;
    end
  end

endmodule

FILE: hdl/wtm_ctrl.sv
// ----------------------------------------------------------------------------
// wtm_ctrl
// sequencer for one item: ring update, multiply, divide, result hand-off
// ----------------------------------------------------------------------------
module wtm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_stall_i,
  input  wtm_pkg::wtm_status_t status_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output wtm_pkg::wtm_cmd_t    cmd_o
);

  import wtm_pkg::*;

  wtm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       div_done;

  assign out_free = !out_valid_q || !out_stall_i;
  assign div_done = !status_i.spd_busy && !status_i.tim_busy;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SUM;
      ST_SUM:    state_d = ST_TDIV;
      ST_TDIV:   state_d = ST_WAIT;
      ST_WAIT:   if (div_done && out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_MUL_LO: cmd_o.mul_lo = 1'b1;
      ST_MUL_HI: begin
        cmd_o.mul_hi    = 1'b1;
        cmd_o.spd_start = 1'b1;
      end
      ST_SUM:    cmd_o.sum = 1'b1;
      ST_TDIV:   cmd_o.tim_start = 1'b1;
      ST_WAIT:   cmd_o.load_out = div_done && out_free;
      default:   cmd_o = '0;
    endcase
  end

  // output valid: set on load, cleared when the item is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/windowed_throughput_meter.sv
// ----------------------------------------------------------------------------
// windowed_throughput_meter
// Each input item reports one sent chunk (bytes and ms since the last chunk).
// The block keeps a ring of the last WINDOW_DEPTH samples, cleared at reset
// through per-slot valid bits, and returns one result item per input item:
// the window speed in KiB/s as unsigned Q.8, the estimated ms left (saturated
// at 2^31-1, zero once the total passes file_size), an empty-window flag and
// the saturating byte total. The 36-step speed divider sets the time from one
// acceptance to the next when the result is taken at once, with the 31-step
// time divider running alongside it after the split multiply and the sum.
// A finished result waits in the output register while the next item is
// accepted. file_size is written over the APB port at byte address 0 and
// must be written only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_throughput_meter #(
  parameter int unsigned WINDOW_DEPTH = wtm_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // chunk items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [wtm_pkg::BYTES_W-1:0]    bytes_sent_i,
  input  logic [wtm_pkg::MS_W-1:0]       elapsed_ms_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [wtm_pkg::SPEED_W-1:0]    speed_q8_o,
  output logic [wtm_pkg::TIME_W-1:0]     time_left_ms_o,
  output logic                           no_rate_o,
  output logic [wtm_pkg::TOTAL_W-1:0]    total_sent_o,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wtm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wtm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wtm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  import wtm_pkg::*;

  wtm_cmd_t             cmd;
  wtm_status_t          status;
  logic [TOTAL_W-1:0]   file_size_q;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  // register index from the 8-byte aligned address
  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  // file size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
    end else if (cfg_wr && (reg_idx == REG_FILE_SIZE)) begin
      file_size_q <= pwdata[TOTAL_W-1:0];
    end
  end

  // read back
  assign prdata = (reg_idx == REG_FILE_SIZE) ? CFG_DATA_W'(file_size_q) : '0;

  wtm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  wtm_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .bytes_sent_i   (bytes_sent_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .file_size_i    (file_size_q),
    .speed_q8_o     (speed_q8_o),
    .time_left_ms_o (time_left_ms_o),
    .no_rate_o      (no_rate_o),
    .total_sent_o   (total_sent_o)
  );

  // accepted item makes the block busy
  `WTM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // results load only once both dividers have finished
  `WTM_ASSERT_NOW(a_load_after_div, cmd.load_out, !status.spd_busy && !status.tim_busy)
  // a waiting result is never overwritten
  `WTM_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid_o || !out_stall_i)
  // speed divider runs after its start
  `WTM_ASSERT_NEXT(a_spd_runs, cmd.spd_start, status.spd_busy)

endmodule
